[rtl/ntp_offset_delay_calc_top_defines.svh]
// Assertion macros for the NTP offset and delay block.
`ifndef NTP_OFFSET_DELAY_CALC_TOP_DEFINES_SVH
`define NTP_OFFSET_DELAY_CALC_TOP_DEFINES_SVH

`ifndef SYNTH

`define ODC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntp_odc: implication check failed");

`define ODC_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("ntp_odc: delayed check failed");

`else

`define ODC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ODC_ASSERT_DELAY(lbl, clk, rst, ante, n, cons)

`endif

`endif

[rtl/ntp_odc_pkg.sv]
`default_nettype none

package ntp_odc_pkg;

   localparam logic [31:0] EPOCH_SHIFT = 32'h83aa7e80;
   localparam logic [19:0] US_PER_SEC  = 20'd1000000;
   localparam logic [12:0] FRAC_MUL    = 13'd4294;
   localparam logic [10:0] FRAC_COR    = 11'd1981;
   localparam logic [9:0]  USEC_COR    = 10'd759;
   localparam logic [15:0] USEC_RND    = 16'd32768;

   typedef struct packed {
      logic [31:0] orig_ntp_sec;
      logic [31:0] orig_ntp_frac;
      logic [31:0] recv_ntp_sec;
      logic [31:0] recv_ntp_frac;
      logic [31:0] xmit_ntp_sec;
      logic [31:0] xmit_ntp_frac;
      logic [31:0] dest_unix_sec;
      logic [19:0] dest_usec;
   } req_type;

   typedef struct packed {
      logic [31:0] t1_sec;
      logic [31:0] t2_sec;
      logic [31:0] t3_sec;
      logic [31:0] dest_sec;
      logic [19:0] t1_us;
      logic [19:0] t2_us;
      logic [19:0] t3_us;
      logic [19:0] dest_us;
      logic [31:0] dest_frac;
   } conv_type;

   typedef struct packed {
      logic signed [33:0] off_sec;
      logic signed [33:0] dly_sec;
      logic signed [21:0] off_us;
      logic signed [21:0] dly_us;
      logic [19:0]        fix_us;
      logic [31:0]        dest_sec;
   } diff_type;

   typedef struct packed {
      logic signed [63:0] off_num;
      logic signed [63:0] dly;
      logic signed [32:0] half_sec;
      logic signed [22:0] half_rem;
      logic [19:0]        fix_us;
      logic [31:0]        dest_sec;
   } scale_type;

   function automatic logic [19:0] frac_to_usec(input logic [31:0] x);
      logic [22:0] rnd;
      logic [6:0]  corr;
      logic [15:0] sub;
      rnd  = {1'b0, x[31:10]} + {7'd0, USEC_RND};
      corr = rnd[22:16];
      sub  = {6'd0, USEC_COR} * {9'd0, corr};
      return x[31:12] - {4'd0, sub};
   endfunction

   function automatic logic [31:0] usec_to_frac(input logic [19:0] u);
      logic [32:0] hi;
      logic [30:0] lo;
      hi = {20'd0, FRAC_MUL} * {13'd0, u};
      lo = {20'd0, FRAC_COR} * {11'd0, u};
      return hi[31:0] + {12'd0, lo[30:11]};
   endfunction

endpackage

`default_nettype wire

[rtl/ntp_offset_delay_calc_top.sv]
// Channel    Ports                 Dir  Handshake
// request    start, busy, req_*    in   taken when start is high and busy is low
// response   rsp_valid, rsp_*      out  one-cycle strobe, no back-pressure
//
// A request is taken in any cycle outside reset; it passes the input register and
// the conv, diff, scale and norm stages, and a new request may follow every cycle.
// The stage that sets the clock is the 34 x 21 bit seconds-to-microseconds multiply.
// Reset is synchronous and clears all valid flags; busy is high only during reset.
// The receiver cannot stall, so nothing ever waits inside the pipeline.
`default_nettype none

`include "ntp_offset_delay_calc_top_defines.svh"

module ntp_offset_delay_calc_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [31:0]  req_orig_ntp_sec,
   input  wire logic [31:0]  req_orig_ntp_frac,
   input  wire logic [31:0]  req_recv_ntp_sec,
   input  wire logic [31:0]  req_recv_ntp_frac,
   input  wire logic [31:0]  req_xmit_ntp_sec,
   input  wire logic [31:0]  req_xmit_ntp_frac,
   input  wire logic [31:0]  req_dest_unix_sec,
   input  wire logic [19:0]  req_dest_usec,
   output logic              rsp_valid,
   output logic signed [63:0] rsp_offset_us,
   output logic signed [63:0] rsp_delay_us,
   output logic signed [63:0] rsp_new_sec,
   output logic [19:0]       rsp_new_usec
);

   logic                   in_vld_ff, in_vld_in;
   ntp_odc_pkg::req_type   in_ff, in_in;
   logic                   conv_vld;
   ntp_odc_pkg::conv_type  conv;
   logic                   diff_vld;
   ntp_odc_pkg::diff_type  diff;
   logic                   scale_vld;
   ntp_odc_pkg::scale_type scale;

   assign busy      = reset;
   assign in_vld_in = start & ~busy;

   always_comb begin
      in_in.orig_ntp_sec  = req_orig_ntp_sec;
      in_in.orig_ntp_frac = req_orig_ntp_frac;
      in_in.recv_ntp_sec  = req_recv_ntp_sec;
      in_in.recv_ntp_frac = req_recv_ntp_frac;
      in_in.xmit_ntp_sec  = req_xmit_ntp_sec;
      in_in.xmit_ntp_frac = req_xmit_ntp_frac;
      in_in.dest_unix_sec = req_dest_unix_sec;
      in_in.dest_usec     = req_dest_usec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   ntp_odc_conv u_conv (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld_ff),
      .req      (in_ff),
      .conv_vld (conv_vld),
      .conv     (conv)
   );

   ntp_odc_diff u_diff (
      .clock    (clock),
      .reset    (reset),
      .conv_vld (conv_vld),
      .conv     (conv),
      .diff_vld (diff_vld),
      .diff     (diff)
   );

   ntp_odc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .diff_vld  (diff_vld),
      .diff      (diff),
      .scale_vld (scale_vld),
      .scale     (scale)
   );

   ntp_odc_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .scale_vld  (scale_vld),
      .scale      (scale),
      .rsp_vld    (rsp_valid),
      .rsp_offset (rsp_offset_us),
      .rsp_delay  (rsp_delay_us),
      .rsp_sec    (rsp_new_sec),
      .rsp_usec   (rsp_new_usec)
   );

   `ODC_ASSERT_IMPLY(a_usec_range, clock, reset, rsp_valid, rsp_new_usec < ntp_odc_pkg::US_PER_SEC)
   `ODC_ASSERT_DELAY(a_req_to_rsp, clock, reset, start && !busy, 5, rsp_valid)
   `ODC_ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, 5))

endmodule

`default_nettype wire

[rtl/ntp_odc_conv.sv]
`default_nettype none

module ntp_odc_conv (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_vld,
   input  wire ntp_odc_pkg::req_type req,
   output logic                      conv_vld,
   output ntp_odc_pkg::conv_type     conv
);

   logic                  vld_ff;
   ntp_odc_pkg::conv_type conv_ff;
   ntp_odc_pkg::conv_type conv_in;

   always_comb begin
      conv_in.t1_sec    = req.orig_ntp_sec - ntp_odc_pkg::EPOCH_SHIFT;
      conv_in.t2_sec    = req.recv_ntp_sec - ntp_odc_pkg::EPOCH_SHIFT;
      conv_in.t3_sec    = req.xmit_ntp_sec - ntp_odc_pkg::EPOCH_SHIFT;
      conv_in.dest_sec  = req.dest_unix_sec;
      conv_in.t1_us     = ntp_odc_pkg::frac_to_usec(req.orig_ntp_frac);
      conv_in.t2_us     = ntp_odc_pkg::frac_to_usec(req.recv_ntp_frac);
      conv_in.t3_us     = ntp_odc_pkg::frac_to_usec(req.xmit_ntp_frac);
      conv_in.dest_us   = req.dest_usec;
      conv_in.dest_frac = ntp_odc_pkg::usec_to_frac(req.dest_usec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      conv_ff <= conv_in;
   end

   assign conv_vld = vld_ff;
   assign conv     = conv_ff;

endmodule

`default_nettype wire

[rtl/ntp_odc_diff.sv]
`default_nettype none

module ntp_odc_diff (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  conv_vld,
   input  wire ntp_odc_pkg::conv_type conv,
   output logic                       diff_vld,
   output ntp_odc_pkg::diff_type      diff
);

   logic                  vld_ff;
   ntp_odc_pkg::diff_type diff_ff;
   ntp_odc_pkg::diff_type diff_in;

   logic signed [33:0] s1, s2, s3, s4;
   logic signed [21:0] u1, u2, u3, u4;

   always_comb begin
      s1 = $signed({2'b00, conv.t1_sec});
      s2 = $signed({2'b00, conv.t2_sec});
      s3 = $signed({2'b00, conv.t3_sec});
      s4 = $signed({2'b00, conv.dest_sec});
      u1 = $signed({2'b00, conv.t1_us});
      u2 = $signed({2'b00, conv.t2_us});
      u3 = $signed({2'b00, conv.t3_us});
      u4 = $signed({2'b00, conv.dest_us});
      diff_in.off_sec  = (s2 - s1) + (s3 - s4);
      diff_in.dly_sec  = (s2 - s1) + (s4 - s3);
      diff_in.off_us   = (u2 - u1) + (u3 - u4);
      diff_in.dly_us   = (u2 - u1) + (u4 - u3);
      diff_in.fix_us   = ntp_odc_pkg::frac_to_usec(conv.dest_frac);
      diff_in.dest_sec = conv.dest_sec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= conv_vld;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   assign diff_vld = vld_ff;
   assign diff     = diff_ff;

endmodule

`default_nettype wire

[rtl/ntp_odc_scale.sv]
`default_nettype none

module ntp_odc_scale (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  diff_vld,
   input  wire ntp_odc_pkg::diff_type diff,
   output logic                       scale_vld,
   output ntp_odc_pkg::scale_type     scale
);

   localparam logic signed [20:0] US_SGN = $signed({1'b0, ntp_odc_pkg::US_PER_SEC});

   logic                   vld_ff;
   ntp_odc_pkg::scale_type scale_ff;
   ntp_odc_pkg::scale_type scale_in;

   logic signed [63:0] off_prod;
   logic signed [63:0] dly_prod;
   logic [19:0]        odd_us;

   always_comb begin
      off_prod = $signed(diff.off_sec) * US_SGN;
      dly_prod = $signed(diff.dly_sec) * US_SGN;
      odd_us   = diff.off_sec[0] ? ntp_odc_pkg::US_PER_SEC : 20'd0;
      scale_in.off_num  = off_prod + 64'($signed(diff.off_us));
      scale_in.dly      = dly_prod + 64'($signed(diff.dly_us));
      scale_in.half_sec = diff.off_sec[33:1];
      scale_in.half_rem = $signed({3'b000, odd_us})
                        + $signed({diff.off_us[21], diff.off_us});
      scale_in.fix_us   = diff.fix_us;
      scale_in.dest_sec = diff.dest_sec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= diff_vld;
      end
   end

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
   end

   assign scale_vld = vld_ff;
   assign scale     = scale_ff;

endmodule

`default_nettype wire

[rtl/ntp_odc_norm.sv]
`default_nettype none

module ntp_odc_norm (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   scale_vld,
   input  wire ntp_odc_pkg::scale_type scale,
   output logic                        rsp_vld,
   output logic signed [63:0]          rsp_offset,
   output logic signed [63:0]          rsp_delay,
   output logic signed [63:0]          rsp_sec,
   output logic [19:0]                 rsp_usec
);

   localparam logic signed [22:0] US_1 = 23'(ntp_odc_pkg::US_PER_SEC);
   localparam logic signed [22:0] US_2 = 23'(2 * ntp_odc_pkg::US_PER_SEC);

   logic               vld_ff;
   logic signed [63:0] offset_ff, offset_in;
   logic signed [63:0] delay_ff;
   logic signed [63:0] sec_ff, sec_in;
   logic [19:0]        usec_ff, usec_in;

   logic               neg;
   logic [63:0]        off_sum;
   logic signed [21:0] half_w;
   logic signed [22:0] tot_us;
   logic signed [22:0] rem_us;
   logic signed [2:0]  carry;

   always_comb begin
      neg       = scale.off_num[63];
      off_sum   = scale.off_num + {63'd0, neg};
      offset_in = $signed({off_sum[63], off_sum[63:1]});
      half_w    = $signed(scale.half_rem[22:1]) + $signed({21'd0, neg & scale.half_rem[0]});
      tot_us    = $signed({3'b000, scale.fix_us}) + $signed({half_w[21], half_w});
      priority if (tot_us < -US_1) begin
         carry  = -3'sd2;
         rem_us = tot_us + US_2;
      end else if (tot_us < 23'sd0) begin
         carry  = -3'sd1;
         rem_us = tot_us + US_1;
      end else if (tot_us < US_1) begin
         carry  = 3'sd0;
         rem_us = tot_us;
      end else if (tot_us < US_2) begin
         carry  = 3'sd1;
         rem_us = tot_us - US_1;
      end else begin
         carry  = 3'sd2;
         rem_us = tot_us - US_2;
      end
      usec_in = rem_us[19:0];
      sec_in  = $signed({32'd0, scale.dest_sec})
              + $signed({{31{scale.half_sec[32]}}, scale.half_sec})
              + $signed({{61{carry[2]}}, carry});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= scale_vld;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      delay_ff  <= scale.dly;
      sec_ff    <= sec_in;
      usec_ff   <= usec_in;
   end

   assign rsp_vld    = vld_ff;
   assign rsp_offset = offset_ff;
   assign rsp_delay  = delay_ff;
   assign rsp_sec    = sec_ff;
   assign rsp_usec   = usec_ff;

endmodule

`default_nettype wire

[tb/ntp_offset_delay_calc_top_tb.sv]
`timescale 1ns / 100ps

module ntp_offset_delay_calc_top_tb;

   localparam logic [31:0] EPOCH      = ntp_odc_pkg::EPOCH_SHIFT;
   localparam longint      USEC_PER_S = 1000000;
   localparam int          IDLE_LIMIT = 1000;
   localparam int          RAND_REQS  = 1630;

   typedef struct {
      longint      offset_us;
      longint      delay_us;
      longint      new_sec;
      logic [19:0] new_usec;
   } clock_fix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [31:0] req_orig_ntp_sec  = '0;
   logic [31:0] req_orig_ntp_frac = '0;
   logic [31:0] req_recv_ntp_sec  = '0;
   logic [31:0] req_recv_ntp_frac = '0;
   logic [31:0] req_xmit_ntp_sec  = '0;
   logic [31:0] req_xmit_ntp_frac = '0;
   logic [31:0] req_dest_unix_sec = '0;
   logic [19:0] req_dest_usec     = '0;
   logic               rsp_valid;
   logic signed [63:0] rsp_offset_us;
   logic signed [63:0] rsp_delay_us;
   logic signed [63:0] rsp_new_sec;
   logic [19:0]        rsp_new_usec;

   ntp_odc_pkg::req_type reply_q[$];
   clock_fix_type        fix_q[$];
   ntp_odc_pkg::req_type on_bus;
   int         gap_left   = 0;
   int         burst_left = 0;
   int         taken_cnt  = 0;
   int         err_cnt    = 0;
   int         idle_cycles = 0;

   ntp_offset_delay_calc_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_orig_ntp_sec  (req_orig_ntp_sec),
      .req_orig_ntp_frac (req_orig_ntp_frac),
      .req_recv_ntp_sec  (req_recv_ntp_sec),
      .req_recv_ntp_frac (req_recv_ntp_frac),
      .req_xmit_ntp_sec  (req_xmit_ntp_sec),
      .req_xmit_ntp_frac (req_xmit_ntp_frac),
      .req_dest_unix_sec (req_dest_unix_sec),
      .req_dest_usec     (req_dest_usec),
      .rsp_valid         (rsp_valid),
      .rsp_offset_us     (rsp_offset_us),
      .rsp_delay_us      (rsp_delay_us),
      .rsp_new_sec       (rsp_new_sec),
      .rsp_new_usec      (rsp_new_usec)
   );

   function automatic logic [31:0] frac_as_usec(input logic [31:0] x);
      logic [31:0] corr;
      corr = ((x >> 10) + 32'd32768) >> 16;
      return (x >> 12) - 32'd759 * corr;
   endfunction

   function automatic logic [31:0] usec_as_frac(input logic [19:0] u);
      logic [63:0] v;
      v = 64'd4294 * u + ((64'd1981 * u) >> 11);
      return v[31:0];
   endfunction

   function automatic longint ntp_as_unix_us(input logic [31:0] sec, input logic [31:0] frac);
      logic [31:0] s;
      s = sec - EPOCH;
      return longint'({32'd0, s}) * USEC_PER_S + longint'({32'd0, frac_as_usec(frac)});
   endfunction

   function automatic clock_fix_type solve_clock_fix(input ntp_odc_pkg::req_type rq);
      longint t1, t2, t3, t4, dsec, total, q, r;
      clock_fix_type fx;
      t1   = ntp_as_unix_us(rq.orig_ntp_sec, rq.orig_ntp_frac);
      t2   = ntp_as_unix_us(rq.recv_ntp_sec, rq.recv_ntp_frac);
      t3   = ntp_as_unix_us(rq.xmit_ntp_sec, rq.xmit_ntp_frac);
      dsec = longint'({32'd0, rq.dest_unix_sec});
      t4   = dsec * USEC_PER_S + longint'({44'd0, rq.dest_usec});
      fx.offset_us = ((t2 - t1) + (t3 - t4)) / 2;
      fx.delay_us  = (t2 - t1) + (t4 - t3);
      total = dsec * USEC_PER_S
            + longint'({32'd0, frac_as_usec(usec_as_frac(rq.dest_usec))}) + fx.offset_us;
      q = total / USEC_PER_S;
      r = total % USEC_PER_S;
      if (r < 0) begin
         r += USEC_PER_S;
         q -= 1;
      end
      fx.new_sec  = q;
      fx.new_usec = r[19:0];
      return fx;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (r < 2) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_reply(input logic [31:0] t1s, input logic [31:0] t1f,
                            input logic [31:0] t2s, input logic [31:0] t2f,
                            input logic [31:0] t3s, input logic [31:0] t3f,
                            input logic [31:0] ds, input logic [19:0] dus);
      ntp_odc_pkg::req_type rq;
      rq.orig_ntp_sec  = t1s;
      rq.orig_ntp_frac = t1f;
      rq.recv_ntp_sec  = t2s;
      rq.recv_ntp_frac = t2f;
      rq.xmit_ntp_sec  = t3s;
      rq.xmit_ntp_frac = t3f;
      rq.dest_unix_sec = ds;
      rq.dest_usec     = dus;
      reply_q.push_back(rq);
   endtask

   task automatic log_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      err_cnt++;
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            fix_q.push_back(solve_clock_fix(on_bus));
            taken_cnt++;
         end
         if (start && busy) begin
            // hold the request
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (reply_q.size() > 0) begin
            on_bus = reply_q.pop_front();
            req_orig_ntp_sec  <= on_bus.orig_ntp_sec;
            req_orig_ntp_frac <= on_bus.orig_ntp_frac;
            req_recv_ntp_sec  <= on_bus.recv_ntp_sec;
            req_recv_ntp_frac <= on_bus.recv_ntp_frac;
            req_xmit_ntp_sec  <= on_bus.xmit_ntp_sec;
            req_xmit_ntp_frac <= on_bus.xmit_ntp_frac;
            req_dest_unix_sec <= on_bus.dest_unix_sec;
            req_dest_usec     <= on_bus.dest_usec;
            start    <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      clock_fix_type fx;
      if (!reset && rsp_valid) begin
         if (fix_q.size() == 0) begin
            log_mismatch("response with no request outstanding");
         end else begin
            fx = fix_q.pop_front();
            if (rsp_offset_us !== fx.offset_us)
               log_mismatch($sformatf("offset_us got %0d expected %0d",
                                      rsp_offset_us, fx.offset_us));
            if (rsp_delay_us !== fx.delay_us)
               log_mismatch($sformatf("delay_us got %0d expected %0d",
                                      rsp_delay_us, fx.delay_us));
            if (rsp_new_sec !== fx.new_sec)
               log_mismatch($sformatf("new_sec got %0d expected %0d",
                                      rsp_new_sec, fx.new_sec));
            if (rsp_new_usec !== fx.new_usec)
               log_mismatch($sformatf("new_usec got %0d expected %0d",
                                      rsp_new_usec, fx.new_usec));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ntp_offset_delay_calc_top test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [31:0] unix_s, t1s, t2s, t3s, ds;
      logic [19:0] dus;
      int          skew, total_reqs;

      add_reply('0, '0, '0, '0, '0, '0, '0, '0);
      add_reply('1, '1, '1, '1, '1, '1, '1, 20'hFFFFF);
      add_reply(EPOCH, '0, EPOCH, '0, EPOCH, '0, '0, '0);
      add_reply(EPOCH - 1, '0, EPOCH, '0, EPOCH, '0, '0, '0);
      add_reply(EPOCH, '0, EPOCH - 1, '1, EPOCH, '0, '0, '0);
      add_reply(EPOCH + 10, '1, EPOCH + 10, '1, EPOCH + 10, '1, 32'd10, 20'd999999);
      add_reply(EPOCH, 32'h80000000, EPOCH, 32'h40000000, EPOCH, 32'hC0000000, 32'd0,
                20'd500000);
      add_reply(EPOCH, 32'h01FFFFFF, EPOCH, 32'h02000000, EPOCH, 32'h020003FF, 32'd0,
                20'd7);
      add_reply(EPOCH + 3, 32'h12345678, EPOCH + 3, 32'h9ABCDEF0, EPOCH + 3, '0, 32'd3,
                20'd1000000);
      add_reply(EPOCH - 1, 32'hFFFFFFFF, EPOCH - 1, 32'h0, EPOCH - 1, 32'h1000,
                32'hFFFFFFFF, 20'hFFFFF);
      // odd numerators around zero: truncate toward zero
      add_reply(EPOCH, '0, EPOCH, '0, EPOCH + 5, '0, 32'd5, 20'd1);
      add_reply(EPOCH, '0, EPOCH, '0, EPOCH + 5, 32'd4096, 32'd5, 20'd0);
      add_reply(EPOCH, '0, EPOCH, '0, EPOCH + 5, '0, 32'd5, 20'd3);
      // typical replies, clock ahead and clock behind
      add_reply(EPOCH + 32'h65000000, 32'h10000000, EPOCH + 32'h65000005, 32'h20000000,
                EPOCH + 32'h65000005, 32'h30000000, 32'h65000000, 20'd200000);
      add_reply(EPOCH + 32'h65000010, 32'h10000000, EPOCH + 32'h65000003, 32'h20000000,
                EPOCH + 32'h65000003, 32'h30000000, 32'h65000010, 20'd300000);
      // large corrections, one negative below zero seconds
      add_reply(EPOCH + 100, '0, EPOCH, '0, EPOCH, '0, 32'd0, 20'd10);
      add_reply(EPOCH, '0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,
                20'd0);
      add_reply(32'hFFFFFFFF, 32'hFFFFFFFF, EPOCH, '0, EPOCH, '0, 32'hFFFFFFFF, 20'd999999);

      for (int i = 0; i < RAND_REQS; i++) begin
         if ($urandom_range(0, 99) < 80) begin
            unix_s = $urandom;
            if ($urandom_range(0, 9) < 8)
               skew = $urandom_range(0, 20) - 10;
            else
               skew = $urandom_range(0, 2000000) - 1000000;
            t1s = unix_s + EPOCH;
            t2s = t1s + skew + $urandom_range(0, 1);
            t3s = t2s + $urandom_range(0, 1);
            ds  = unix_s + $urandom_range(0, 2);
            if ($urandom_range(0, 19) == 0)
               dus = 20'($urandom_range(1000000, 1048575));
            else
               dus = 20'($urandom_range(0, 999999));
            add_reply(t1s, $urandom, t2s, $urandom, t3s, $urandom, ds, dus);
         end else begin
            add_reply($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      20'($urandom_range(0, 1048575)));
         end
      end
      total_reqs = reply_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (taken_cnt < total_reqs) @(posedge clock);
      while (fix_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_cnt == 0) begin
         $display("ntp_offset_delay_calc_top test passed");
      end else begin
         $display("ntp_offset_delay_calc_top test failed");
      end
      $finish;
   end

endmodule

[ntp_offset_delay_calc_top.f]
+incdir+rtl
rtl/ntp_odc_pkg.sv
rtl/ntp_odc_conv.sv
rtl/ntp_odc_diff.sv
rtl/ntp_odc_scale.sv
rtl/ntp_odc_norm.sv
rtl/ntp_offset_delay_calc_top.sv
tb/ntp_offset_delay_calc_top_tb.sv
